// ----- src/swcr_pkg.sv -----
package swcr_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int BTN_W       = 2;
  localparam int STAMP_W     = 32;
  localparam int WIN_W       = 16;
  localparam int TOTAL_W     = 32;
  localparam int OUT_CNT_W   = 7;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 56;
  localparam int S_TUSER_W   = 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [BTN_W-1:0] BTN_LAST     = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLICK  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD,
    ST_CMP,
    ST_PEAK,
    ST_OUT
  } state_e;

endpackage

// ----- src/sliding_window_click_rate_meter_core.sv -----
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tdata: player, button, now_ms; tuser: command
// m_axis    out        tvalid/tready, tlast  tdata: player, button, count, total, peak
// cfg       in         we (no wait)          wdata: window_ms
//
// A click or a clear passes through the dispatch state and then back to ready.
// An update then visits read, compare, peak and output for each button; compare
// repeats per expired stamp plus a final check, skipped when a ring is or ends empty;
// the single read port of the stamp memory pops one stamp a cycle.
// m_axis back-pressure holds the output state; the input is held off meanwhile.
// Reset clears all counters and sets the window to 1000 ms; the stamp memory
// is not cleared, only stamps within a ring's count are ever read.
module sliding_window_click_rate_meter_core #(
  parameter int RING_DEPTH = 64,
  parameter int PLAYERS    = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [swcr_pkg::WIN_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [0] player, [2:1] button, [34:3] now_ms, [39:35] zero
  input  logic [swcr_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // [1:0] command
  input  logic [swcr_pkg::S_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] out_player, [2:1] out_button, [9:3] window_count, [41:10] total_clicks,
  // [48:42] peak_count, [55:49] zero
  output logic [swcr_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  localparam int NCTR   = PLAYERS * swcr_pkg::NUM_BUTTONS;
  localparam int CIDX_W = $clog2(NCTR);
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int OCW    = swcr_pkg::OUT_CNT_W;

  swcr_pkg::state_e state_q, state_d;
  swcr_pkg::cmd_e   cmd_q;
  logic                          player_q;
  logic [swcr_pkg::BTN_W-1:0]    btn_q, btn_d;
  logic [swcr_pkg::STAMP_W-1:0]  now_q;
  logic [swcr_pkg::WIN_W-1:0]    window_q;

  logic [SLOT_W-1:0]             head_q  [NCTR];
  logic [CNT_W-1:0]              count_q [NCTR];
  logic [swcr_pkg::TOTAL_W-1:0]  total_q [NCTR];
  logic [CNT_W-1:0]              peak_q  [NCTR];

  logic                          out_player_q;
  logic [swcr_pkg::BTN_W-1:0]    out_button_q;
  logic [OCW-1:0]                out_count_q;
  logic [swcr_pkg::TOTAL_W-1:0]  out_total_q;
  logic [OCW-1:0]                out_peak_q;
  logic                          out_last_q;

  logic                          s_accept;
  logic                          item_ok;
  logic [CIDX_W-1:0]             ctr;
  logic [SLOT_W-1:0]             cur_head;
  logic [CNT_W-1:0]              cur_count;
  logic [swcr_pkg::TOTAL_W-1:0]  cur_total;
  logic [CNT_W-1:0]              cur_peak;
  logic [CNT_W-1:0]              peak_new;
  logic [SLOT_W-1:0]             head_inc;
  logic [SLOT_W:0]               slot_sum;
  logic [SLOT_W-1:0]             wr_slot;
  logic                          ring_full;
  logic [SLOT_W-1:0]             rd_slot;
  logic [swcr_pkg::STAMP_W-1:0]  rd_stamp;
  logic [swcr_pkg::STAMP_W-1:0]  age;
  logic                          expire;
  logic                          click_en, clear_en, pop_en, peak_en, ram_we;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign item_ok  = 32'(player_q) < PLAYERS;
  assign ctr      = CIDX_W'(32'(player_q) * swcr_pkg::NUM_BUTTONS + 32'(btn_q));

  assign cur_head  = head_q[ctr];
  assign cur_count = count_q[ctr];
  assign cur_total = total_q[ctr];
  assign cur_peak  = peak_q[ctr];
  assign peak_new  = (cur_count > cur_peak) ? cur_count : cur_peak;

  assign head_inc  = (cur_head == SLOT_W'(RING_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign slot_sum  = (SLOT_W + 1)'(cur_head) + (SLOT_W + 1)'(cur_count);
  // wrap the tail position back into the ring
  assign wr_slot   = (slot_sum >= (SLOT_W + 1)'(RING_DEPTH)) ?
                     SLOT_W'(slot_sum - (SLOT_W + 1)'(RING_DEPTH)) : SLOT_W'(slot_sum);
  assign ring_full = cur_count == CNT_W'(RING_DEPTH);

  // prefetch the next oldest stamp while popping the current one
  assign rd_slot = pop_en ? head_inc : cur_head;
  assign age     = now_q - rd_stamp;
  assign expire  = age > {{(swcr_pkg::STAMP_W - swcr_pkg::WIN_W){1'b0}}, window_q};
  assign ram_we  = click_en && !ring_full;

  swcr_stamp_ram #(
    .RING_DEPTH(RING_DEPTH),
    .NCTR      (NCTR)
  ) u_stamp_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_ctr_i (ctr),
    .wr_slot_i(wr_slot),
    .wr_data_i(now_q),
    .rd_ctr_i (ctr),
    .rd_slot_i(rd_slot),
    .rd_data_o(rd_stamp)
  );

  always_comb begin
    state_d  = state_q;
    btn_d    = btn_q;
    click_en = 1'b0;
    clear_en = 1'b0;
    pop_en   = 1'b0;
    peak_en  = 1'b0;
    case (state_q)
      swcr_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = swcr_pkg::ST_DISPATCH;
        end
      end
      swcr_pkg::ST_DISPATCH: begin
        state_d = swcr_pkg::ST_IDLE;
        if (item_ok) begin
          case (cmd_q)
            swcr_pkg::CMD_CLICK: begin
              click_en = 32'(btn_q) < swcr_pkg::NUM_BUTTONS;
            end
            swcr_pkg::CMD_CLEAR: begin
              clear_en = 1'b1;
            end
            swcr_pkg::CMD_UPDATE: begin
              btn_d   = '0;
              state_d = swcr_pkg::ST_RD;
            end
            default: begin
              state_d = swcr_pkg::ST_IDLE;
            end
          endcase
        end
      end
      swcr_pkg::ST_RD: begin
        state_d = (cur_count == '0) ? swcr_pkg::ST_PEAK : swcr_pkg::ST_CMP;
      end
      swcr_pkg::ST_CMP: begin
        if (expire) begin
          pop_en  = 1'b1;
          state_d = (cur_count == CNT_W'(1)) ? swcr_pkg::ST_PEAK : swcr_pkg::ST_CMP;
        end else begin
          state_d = swcr_pkg::ST_PEAK;
        end
      end
      swcr_pkg::ST_PEAK: begin
        peak_en = 1'b1;
        state_d = swcr_pkg::ST_OUT;
      end
      swcr_pkg::ST_OUT: begin
        if (m_axis_tready_i) begin
          if (btn_q == swcr_pkg::BTN_LAST) begin
            state_d = swcr_pkg::ST_IDLE;
          end else begin
            btn_d   = btn_q + 1'b1;
            state_d = swcr_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_d = swcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swcr_pkg::ST_IDLE;
      window_q <= swcr_pkg::WINDOW_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  // hold the accepted transaction; the button steps through the buttons during an update
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q    <= swcr_pkg::cmd_e'(s_axis_tuser_i);
      player_q <= s_axis_tdata_i[0];
      btn_q    <= s_axis_tdata_i[2:1];
      now_q    <= s_axis_tdata_i[34:3];
    end else begin
      btn_q    <= btn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCTR; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
        total_q[i] <= '0;
        peak_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NCTR; i++) begin
        if (clear_en && (i / swcr_pkg::NUM_BUTTONS) == 32'(player_q)) begin
          head_q[i]  <= '0;
          count_q[i] <= '0;
          total_q[i] <= '0;
          peak_q[i]  <= '0;
        end
        if (click_en && ctr == CIDX_W'(i)) begin
          if (!ring_full) begin
            count_q[i] <= cur_count + 1'b1;
          end
          if (cur_total != '1) begin
            total_q[i] <= cur_total + 1'b1;
          end
        end
        if (pop_en && ctr == CIDX_W'(i)) begin
          head_q[i]  <= head_inc;
          count_q[i] <= cur_count - 1'b1;
        end
        if (peak_en && ctr == CIDX_W'(i)) begin
          peak_q[i] <= peak_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (peak_en) begin
      out_player_q <= player_q;
      out_button_q <= btn_q;
      out_count_q  <= OCW'(cur_count);
      out_total_q  <= cur_total;
      out_peak_q   <= OCW'(peak_new);
      out_last_q   <= btn_q == swcr_pkg::BTN_LAST;
    end
  end

  assign s_axis_tready_o = state_q == swcr_pkg::ST_IDLE;
  assign m_axis_tvalid_o = state_q == swcr_pkg::ST_OUT;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {7'b0, out_peak_q, out_total_q, out_count_q,
                            out_button_q, out_player_q};

endmodule

// ----- src/swcr_stamp_ram.sv -----
module swcr_stamp_ram #(
  parameter int RING_DEPTH = 64,
  parameter int NCTR       = 6
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(NCTR)-1:0]           wr_ctr_i,
  input  logic [$clog2(RING_DEPTH)-1:0]     wr_slot_i,
  input  logic [swcr_pkg::STAMP_W-1:0]      wr_data_i,
  input  logic [$clog2(NCTR)-1:0]           rd_ctr_i,
  input  logic [$clog2(RING_DEPTH)-1:0]     rd_slot_i,
  output logic [swcr_pkg::STAMP_W-1:0]      rd_data_o
);

  logic [swcr_pkg::STAMP_W-1:0] mem_q [NCTR][RING_DEPTH];
  logic [swcr_pkg::STAMP_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ctr_i][wr_slot_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_ctr_i][rd_slot_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/swcr_checker.sv -----
module swcr_checker #(
  parameter int RING_DEPTH = 64
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [swcr_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  logic m_xfer;
  assign m_xfer = m_axis_tvalid_o && m_axis_tready_i;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped while stalled");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result waits");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("not ready after final result of an update");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast_o |=> !s_axis_tready_o)
    else $error("ready in the middle of an update report");

  a_peak_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (RING_DEPTH >= 128 || m_axis_tdata_o[48:42] >= m_axis_tdata_o[9:3]))
    else $error("peak below window count");

endmodule

bind sliding_window_click_rate_meter_core swcr_checker #(
  .RING_DEPTH(RING_DEPTH)
) u_swcr_checker (.*);
